// ----- hdl/ptts_pkg.sv -----
// Types and constants shared by the periodic task tick scheduler.
// No dependencies.
package ptts_pkg;

  localparam int unsigned BANK_SIZE = 8;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned TASK_W    = 4;
  localparam int unsigned IDX_W     = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET [BANK_SIZE] = '{
    8'd2, 8'd5, 8'd10, 8'd20, 8'd30, 8'd50, 8'd208, 8'd208
  };

  typedef struct packed {
    logic                 run_flag;
    logic [BANK_SIZE-1:0] pending_mask;
  } rsp_t;

endpackage

// ----- hdl/ptts_intf.sv -----
// Valid/ready channel interfaces of the periodic task tick scheduler.
// Depends on ptts_pkg.
interface ptts_req_if import ptts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [TASK_W-1:0] task_req;

  modport source (output valid, op, task_req, input ready);
  modport sink (input valid, op, task_req, output ready);
endinterface

interface ptts_rsp_if import ptts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 run_flag;
  logic [BANK_SIZE-1:0] pending_mask;

  modport source (output valid, run_flag, pending_mask, input ready);
  modport sink (input valid, run_flag, pending_mask, output ready);
endinterface

interface ptts_cfg_if import ptts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    index;
  logic [PERIOD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/periodic_task_tick_scheduler_unit.sv -----
// Periodic task tick scheduler: bank of periodic down-counters with pending flags.
// Depends on ptts_pkg and the channel interfaces in ptts_intf.sv.
//
//   channel  dir  payload                      accepted when
//   req_i    in   op[1:0], task_req[3:0]       valid && ready
//   rsp_o    out  run_flag, pending_mask[7:0]  valid && ready
//   cfg_i    in   index[2:0], data[7:0]        valid && ready (ready tied high)
//
// One transaction per cycle while req_i is ready; its result is registered.
// All counters update in parallel on a tick, so the rate is set only by the output side.
// A two-entry output (result register plus skid register) lets req_i accept one more
// transaction during an output stall; ready drops only while the skid register is full.
// Reset loads the reset periods into counters and period registers, clears all flags.
module periodic_task_tick_scheduler_unit
  import ptts_pkg::*;
#(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptts_req_if.sink   req_i,
  ptts_rsp_if.source rsp_o,
  ptts_cfg_if.sink   cfg_i
);

  logic [PERIOD_W-1:0]  period_q [NUM_TASKS];
  logic [PERIOD_W-1:0]  cnt_q    [NUM_TASKS];
  logic [PERIOD_W-1:0]  cnt_d    [NUM_TASKS];
  logic [PERIOD_W-1:0]  cnt_dec  [NUM_TASKS];
  logic [NUM_TASKS-1:0] flags_q, flags_d;
  logic [BANK_SIZE-1:0] flag_vec;

  rsp_t out_q, skid_q, rsp_new;
  logic out_vld_q, skid_vld_q;

  logic            accept, pop, cfg_wr, in_range;
  logic [IDX_W-1:0] sel;
  op_e             op;

  assign op       = op_e'(req_i.op);
  assign sel      = req_i.task_req[IDX_W-1:0];
  assign in_range = 32'(req_i.task_req) < NUM_TASKS;
  assign accept   = req_i.valid && req_i.ready;
  assign pop      = out_vld_q && rsp_o.ready;
  assign cfg_wr   = cfg_i.valid && cfg_i.ready;
  assign flag_vec = BANK_SIZE'(flags_q);

  assign req_i.ready = !skid_vld_q;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    flags_d = flags_q;
    for (int i = 0; i < NUM_TASKS; i++) begin
      cnt_d[i]   = cnt_q[i];
      cnt_dec[i] = cnt_q[i] - PERIOD_W'(1);
    end
    rsp_new.run_flag = 1'b0;
    if (accept) begin
      case (op)
        OP_TICK: begin
          for (int i = 0; i < NUM_TASKS; i++) begin
            if (cnt_dec[i] == '0) begin
              cnt_d[i]   = period_q[i];
              flags_d[i] = 1'b1;
            end else begin
              cnt_d[i] = cnt_dec[i];
            end
          end
        end
        OP_QUERY: begin
          rsp_new.run_flag = in_range && flag_vec[sel];
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_TASKS; i++) begin
            if (in_range && (32'(sel) == i)) begin
              flags_d[i] = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
    rsp_new.pending_mask = BANK_SIZE'(flags_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        period_q[i] <= PERIOD_RESET[i];
        cnt_q[i]    <= PERIOD_RESET[i];
      end
      flags_q <= '0;
    end else begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (cfg_wr && (32'(cfg_i.index) == i)) begin
          period_q[i] <= cfg_i.data;
        end
      end
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || pop) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= accept;
        end
      end else if (accept) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      out_q <= skid_vld_q ? skid_q : rsp_new;
    end else if (accept) begin
      skid_q <= rsp_new;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.run_flag     = out_q.run_flag;
  assign rsp_o.pending_mask = out_q.pending_mask;

`ifndef SYNTHESIS
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while result register empty");

  a_mask_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.pending_mask >> NUM_TASKS) == '0))
    else $error("pending mask has bits above the channel count");

  a_clear_drops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_CLEAR && in_range) |=> !flag_vec[$past(sel)])
    else $error("clear did not drop the pending flag");

  a_flags_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op != OP_CLEAR) |=> ((flags_q & $past(flags_q)) == $past(flags_q)))
    else $error("pending flag dropped without a clear");

  a_flag_in_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.run_flag) |-> (out_q.pending_mask != '0))
    else $error("run flag set with empty pending mask");
`endif

endmodule
